### rtl/core/dap_pkg.sv
// Shared types and constants for the decimal amount parser.
package dap_pkg;

  // ASCII codes
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Field and register widths
  localparam int CH_W     = 8;
  localparam int AMOUNT_W = 64;
  localparam int REG_W    = 32;
  localparam int DEC_W    = 5;
  localparam int ADDR_W   = 2;
  // whole part never exceeds max_amount * 10 + 9
  localparam int WHOLE_W  = REG_W + 4;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_MAX_AMOUNT   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_UNIT_DIVISOR = 2'd1;
  localparam logic [ADDR_W-1:0] REG_MAX_DECIMALS = 2'd2;

  // Register reset values
  localparam logic [REG_W-1:0] RST_MAX_AMOUNT   = 32'd21000000;
  localparam logic [REG_W-1:0] RST_UNIT_DIVISOR = 32'd100000000;
  localparam logic [DEC_W-1:0] RST_MAX_DECIMALS = 5'd8;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MUL_LIM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_FIN
  } dap_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // input transaction accepted
    logic scale;     // one fraction scaling step
    logic mul_lim;   // limit = max_amount * divisor
    logic mul_lo;    // low partial product of whole * divisor
    logic mul_hi;    // add high partial product
    logic add_frac;  // add scaled fraction
    logic load_out;  // final compare, load result, clear state
  } dap_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scale_done;
    logic out_busy;
  } dap_sts_t;

endpackage

### rtl/core/dap_datapath.sv
// Datapath of the decimal amount parser: registers, accumulators, arithmetic, output stage.
module dap_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dap_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [dap_pkg::REG_W-1:0]     cfg_data,
  input  logic [dap_pkg::CH_W-1:0]      in_ch,
  input  logic                          in_has_char,
  input  dap_pkg::dap_cmd_t             cmd,
  output dap_pkg::dap_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dap_pkg::AMOUNT_W-1:0]  out_amount,
  output logic                          out_error
);

  // Configuration registers
  logic [dap_pkg::REG_W-1:0] max_amt_r, div_r;
  logic [dap_pkg::DEC_W-1:0] max_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_amt_r <= dap_pkg::RST_MAX_AMOUNT;
      div_r     <= dap_pkg::RST_UNIT_DIVISOR;
      max_dec_r <= dap_pkg::RST_MAX_DECIMALS;
    end else if (cfg_we) begin
      case (cfg_addr)
        dap_pkg::REG_MAX_AMOUNT:   max_amt_r <= cfg_data;
        dap_pkg::REG_UNIT_DIVISOR: div_r     <= cfg_data;
        dap_pkg::REG_MAX_DECIMALS: max_dec_r <= cfg_data[dap_pkg::DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Parse state and arithmetic registers
  logic [dap_pkg::WHOLE_W-1:0]  whole_r, whole_nxt;
  logic [dap_pkg::AMOUNT_W-1:0] frac_r, frac_nxt;
  logic [dap_pkg::DEC_W-1:0]    cnt_r, cnt_nxt;
  logic                         in_frac_r, in_frac_nxt;
  logic                         bad_r, bad_nxt;
  logic [dap_pkg::AMOUNT_W-1:0] lim_r, lim_nxt;
  logic [dap_pkg::AMOUNT_W-1:0] prod_r, prod_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [dap_pkg::AMOUNT_W-1:0] out_amount_r, out_amount_nxt;
  logic                         out_error_r, out_error_nxt;

  // Character decode
  logic                         is_digit;
  logic [3:0]                   digit;
  logic [3:0]                   frac_d;
  logic [dap_pkg::WHOLE_W+3:0]  whole10;
  logic [dap_pkg::AMOUNT_W+3:0] frac10;
  logic                         frac_ovf;

  assign is_digit = in_ch inside {[dap_pkg::CH_ZERO:dap_pkg::CH_NINE]};
  assign digit    = is_digit ? 4'(in_ch - dap_pkg::CH_ZERO) : 4'd0;
  // scaling steps shift in a zero digit
  assign frac_d   = cmd.take ? digit : 4'd0;

  // times ten plus digit, as shift-and-add
  assign whole10  = {whole_r, 3'b000} + {2'b00, whole_r, 1'b0}
                  + {{dap_pkg::WHOLE_W{1'b0}}, digit};
  assign frac10   = {frac_r, 3'b000} + {2'b00, frac_r, 1'b0}
                  + {{dap_pkg::AMOUNT_W{1'b0}}, frac_d};
  assign frac_ovf = |frac10[dap_pkg::AMOUNT_W+3:dap_pkg::AMOUNT_W];

  // Shared 32x32 multiplier
  logic [dap_pkg::REG_W-1:0]    mul_a;
  logic [dap_pkg::AMOUNT_W-1:0] mul_p;
  logic [dap_pkg::WHOLE_W-1:0]  hi_p;
  logic [dap_pkg::AMOUNT_W+4:0] hi_sum;
  logic [dap_pkg::AMOUNT_W:0]   add_sum;
  logic                         over_lim;

  assign mul_a    = cmd.mul_lim ? max_amt_r : whole_r[dap_pkg::REG_W-1:0];
  assign mul_p    = mul_a * div_r;
  assign hi_p     = whole_r[dap_pkg::WHOLE_W-1:dap_pkg::REG_W] * div_r;
  assign hi_sum   = {5'd0, prod_r} + {1'b0, hi_p, {dap_pkg::REG_W{1'b0}}};
  assign add_sum  = {1'b0, prod_r} + {1'b0, frac_r};
  assign over_lim = prod_r > lim_r;

  // Next-value logic
  always_comb begin
    whole_nxt      = whole_r;
    frac_nxt       = frac_r;
    cnt_nxt        = cnt_r;
    in_frac_nxt    = in_frac_r;
    bad_nxt        = bad_r;
    lim_nxt        = lim_r;
    prod_nxt       = prod_r;
    out_amount_nxt = out_amount_r;
    out_error_nxt  = out_error_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cmd.take && in_has_char && !bad_r) begin
      if (!in_frac_r) begin
        if (in_ch == dap_pkg::CH_POINT) begin
          in_frac_nxt = 1'b1;
        end else if (whole_r > {4'd0, max_amt_r} || !is_digit) begin
          bad_nxt = 1'b1;
        end else begin
          whole_nxt = whole10[dap_pkg::WHOLE_W-1:0];
        end
      end else begin
        if (cnt_r >= max_dec_r || !is_digit) begin
          bad_nxt = 1'b1;
        end else begin
          cnt_nxt  = cnt_r + 5'd1;
          frac_nxt = frac10[dap_pkg::AMOUNT_W-1:0];
          bad_nxt  = frac_ovf;
        end
      end
    end

    if (cmd.scale) begin
      cnt_nxt  = cnt_r + 5'd1;
      frac_nxt = frac10[dap_pkg::AMOUNT_W-1:0];
      bad_nxt  = frac_ovf;
    end

    if (cmd.mul_lim) lim_nxt = mul_p;
    if (cmd.mul_lo)  prod_nxt = mul_p;

    if (cmd.mul_hi) begin
      prod_nxt = hi_sum[dap_pkg::AMOUNT_W-1:0];
      bad_nxt  = bad_r || (|hi_sum[dap_pkg::AMOUNT_W+4:dap_pkg::AMOUNT_W]);
    end

    if (cmd.add_frac) begin
      prod_nxt = add_sum[dap_pkg::AMOUNT_W-1:0];
      bad_nxt  = bad_r || add_sum[dap_pkg::AMOUNT_W];
    end

    // result to output stage, parse state back to empty string
    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_error_nxt  = bad_r || over_lim;
      out_amount_nxt = (bad_r || over_lim) ? '0 : prod_r;
      whole_nxt      = '0;
      frac_nxt       = '0;
      cnt_nxt        = '0;
      in_frac_nxt    = 1'b0;
      bad_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r     <= '0;
      frac_r      <= '0;
      cnt_r       <= '0;
      in_frac_r   <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      whole_r     <= whole_nxt;
      frac_r      <= frac_nxt;
      cnt_r       <= cnt_nxt;
      in_frac_r   <= in_frac_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r        <= lim_nxt;
    prod_r       <= prod_nxt;
    out_amount_r <= out_amount_nxt;
    out_error_r  <= out_error_nxt;
  end

  // Status and outputs
  assign sts.scale_done = bad_r || (frac_r == '0) || (cnt_r >= max_dec_r);
  assign sts.out_busy   = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_amount     = out_amount_r;
  assign out_error      = out_error_r;

  // Checks
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_load_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (!bad_r && cnt_r == '0 && whole_r == '0 && !in_frac_r))
    else $error("parse state not cleared after string end");

  a_error_zero_amount: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_r |-> out_amount_r == '0)
    else $error("error result carries a nonzero amount");

endmodule

### rtl/core/dap_ctrl.sv
// Controller state machine of the decimal amount parser.
module dap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_is_last,
  output logic              in_stall,
  input  dap_pkg::dap_sts_t sts,
  output dap_pkg::dap_cmd_t cmd
);

  dap_pkg::dap_state_t state_r, state_nxt;
  logic                accept;

  assign accept = in_valid && (state_r == dap_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dap_pkg::ST_IDLE:    if (accept && in_is_last) state_nxt = dap_pkg::ST_SCALE;
      dap_pkg::ST_SCALE:   if (sts.scale_done) state_nxt = dap_pkg::ST_MUL_LIM;
      dap_pkg::ST_MUL_LIM: state_nxt = dap_pkg::ST_MUL_LO;
      dap_pkg::ST_MUL_LO:  state_nxt = dap_pkg::ST_MUL_HI;
      dap_pkg::ST_MUL_HI:  state_nxt = dap_pkg::ST_ADD;
      dap_pkg::ST_ADD:     state_nxt = dap_pkg::ST_FIN;
      dap_pkg::ST_FIN:     if (!sts.out_busy) state_nxt = dap_pkg::ST_IDLE;
      default:             state_nxt = dap_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      dap_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = accept;
      end
      dap_pkg::ST_SCALE:   cmd.scale    = !sts.scale_done;
      dap_pkg::ST_MUL_LIM: cmd.mul_lim  = 1'b1;
      dap_pkg::ST_MUL_LO:  cmd.mul_lo   = 1'b1;
      dap_pkg::ST_MUL_HI:  cmd.mul_hi   = 1'b1;
      dap_pkg::ST_ADD:     cmd.add_frac = 1'b1;
      dap_pkg::ST_FIN:     cmd.load_out = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dap_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded over a pending transaction");

  a_scale_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dap_pkg::ST_SCALE && !sts.scale_done) |=> state_r == dap_pkg::ST_SCALE)
    else $error("left scaling before it finished");

  a_add_after_hi: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dap_pkg::ST_ADD |-> $past(state_r) == dap_pkg::ST_MUL_HI)
    else $error("fraction added before the product was complete");

endmodule

### rtl/core/decimal_amount_parser.sv
// Top level of the decimal amount parser: controller plus datapath.
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_stall, in_ch, in_has_char,      | in
//          | in_is_last                                   |
//  result  | out_valid, out_stall, out_amount, out_error  | out
//  config  | cfg_we, cfg_addr, cfg_data                   | in
//
//  A character without the end mark is taken in idle and leaves the controller idle;
//  in_stall is low in idle. After a string end is taken the input stalls through S
//  fraction scaling steps (up to max_decimals minus fraction digits seen, at most 20 as
//  a nonzero fraction overflows by then), scaling exit, three multiply steps, add, load.
//  The load waits while the previous result is still stalled in the output register.
//  rst_n is synchronous, active low; it restores register defaults and clears parse state.
module decimal_amount_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dap_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [dap_pkg::REG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dap_pkg::CH_W-1:0]      in_ch,
  input  logic                          in_has_char,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dap_pkg::AMOUNT_W-1:0]  out_amount,
  output logic                          out_error
);

  dap_pkg::dap_cmd_t cmd;
  dap_pkg::dap_sts_t sts;

  dap_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  dap_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .in_has_char (in_has_char),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_amount  (out_amount),
    .out_error   (out_error)
  );

endmodule
